/* design/afl_pkg.sv */
// Package for the four-lane AES hash: request/response types, lane constants,
// S-box tables built at elaboration and the single AES round function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package afl_pkg;

  typedef enum logic [1:0] {
    MODE_ABSORB     = 2'd0,
    MODE_ABSORB_FIN = 2'd1,
    MODE_FIN        = 2'd2
  } mode_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] block_word0;
    logic [63:0] block_word1;
    logic [63:0] block_word2;
    logic [63:0] block_word3;
    logic [63:0] block_word4;
    logic [63:0] block_word5;
    logic [63:0] block_word6;
    logic [63:0] block_word7;
  } in_req_t;

  typedef struct packed {
    logic [63:0] digest_word0;
    logic [63:0] digest_word1;
    logic [63:0] digest_word2;
    logic [63:0] digest_word3;
    logic [63:0] digest_word4;
    logic [63:0] digest_word5;
    logic [63:0] digest_word6;
    logic [63:0] digest_word7;
  } out_rsp_t;

  localparam int unsigned NumLanes = 4;

  typedef logic [NumLanes-1:0][127:0] lanes_t;
  typedef logic [255:0][7:0]           sbox_t;

  // Initial lane values, {high, low}
  localparam lanes_t LaneInit = '{
    128'h7e99494879a10005_07ad828d630a240c,
    128'he8a07ce45079506b_ae62c7d06a770017,
    128'hace78057f59e125a_15c7b798338d996e,
    128'hd7983aadcc82db47_9fa856de92b52c0d
  };

  localparam logic [127:0] XKey0 = 128'h0689020190dc56bf_8b24949ff6fa8389;
  localparam logic [127:0] XKey1 = 128'hed18f99bee1043c6_51f4e03c61b263d1;

  function automatic logic [7:0] xt(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] x;
    r = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ x;
      x = xt(x);
    end
    return r;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  // Table generation, evaluated only at elaboration
  function automatic sbox_t gen_sbox(input logic inv);
    sbox_t      t;
    logic [7:0] r;
    logic [7:0] base;
    logic [7:0] f;
    for (int x = 0; x < 256; x++) begin
      r    = 8'h01;
      base = 8'(x);
      for (int e = 0; e < 8; e++) begin
        if (((254 >> e) & 1) == 1) r = gmul(r, base);
        base = gmul(base, base);
      end
      f = r ^ rotl8(r, 1) ^ rotl8(r, 2) ^ rotl8(r, 3) ^ rotl8(r, 4) ^ 8'h63;
      if (inv) t[f] = 8'(x);
      else     t[x] = f;
    end
    return t;
  endfunction

  localparam sbox_t SboxFwd = gen_sbox(1'b0);
  localparam sbox_t SboxInv = gen_sbox(1'b1);

  // One AES round (encrypt or decrypt flavor) with key xor; byte i = row i%4, col i/4
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic dec,
                                              input logic [127:0] key);
    logic [15:0][7:0] t;
    logic [15:0][7:0] m;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (dec) t[r+4*c] = SboxInv[s[8*(r+4*((c-r+4)%4)) +: 8]];
        else     t[r+4*c] = SboxFwd[s[8*(r+4*((c+r)%4)) +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      if (!dec) begin
        m[4*c]   = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
        m[4*c+1] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
        m[4*c+2] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
        m[4*c+3] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
      end else begin
        m[4*c]   = gmul(a0, 8'd14) ^ gmul(a1, 8'd11) ^ gmul(a2, 8'd13) ^ gmul(a3, 8'd9);
        m[4*c+1] = gmul(a0, 8'd9) ^ gmul(a1, 8'd14) ^ gmul(a2, 8'd11) ^ gmul(a3, 8'd13);
        m[4*c+2] = gmul(a0, 8'd13) ^ gmul(a1, 8'd9) ^ gmul(a2, 8'd14) ^ gmul(a3, 8'd11);
        m[4*c+3] = gmul(a0, 8'd11) ^ gmul(a1, 8'd13) ^ gmul(a2, 8'd9) ^ gmul(a3, 8'd14);
      end
    end
    return m ^ key;
  endfunction

  // Round on all lanes: odd lanes decrypt
  function automatic lanes_t round_lanes(input lanes_t st, input lanes_t keys);
    lanes_t o;
    for (int k = 0; k < NumLanes; k++) begin
      o[k] = aes_round(st[k], k[0], keys[k]);
    end
    return o;
  endfunction

endpackage
`default_nettype wire

/* design/aes_four_lane_hash.sv */
// Four-lane AES hash, top level. Absorb round on the lane state, then a
// finalization pipeline. Depends on afl_pkg.
//
// Usage:
//   Input channel in_valid_i / in_stall_o / in_req_i carries one 64-byte block
//   and a mode per request: absorb, absorb then finalize, or finalize only.
//   Output channel out_valid_o / out_stall_i / out_rsp_o carries the 512-bit
//   digest, one response per finalizing request.
//   Throughput: one request per cycle while in_stall_o is low; the absorb
//   round updates the lane state in the cycle a request is taken.
//   A finalizing request has its absorbed lanes captured at the edge that
//   accepts it, then a round with the first extra key, then a round with the
//   second extra key into the output register, which drives out_valid_o.
//   A finalizing request reloads the lane constants at once, so the next
//   message may start in the following cycle.
//   Reset loads the lane constants and empties the finalization pipeline.
//   When the receiver stalls, the pipeline fills; in_stall_o rises only when
//   all three finalization stages are occupied and out_stall_i is high.
`timescale 1ns / 1ps
`default_nettype none
module aes_four_lane_hash (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire afl_pkg::in_req_t  in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output afl_pkg::out_rsp_t      out_rsp_o
);
  import afl_pkg::*;

  lanes_t lane_q, lane_d;
  lanes_t fa_q, fb_q, out_q;
  logic   fa_v_q, fb_v_q, out_v_q;
  logic   adv_out, adv_fb, adv_fa;
  logic   accept, absorb, fin;
  lanes_t keys;
  lanes_t absorbed;
  lanes_t key0, key1;

  // Pipeline advance, back to front
  assign adv_out    = !out_v_q || !out_stall_i;
  assign adv_fb     = !fb_v_q || adv_out;
  assign adv_fa     = !fa_v_q || adv_fb;
  assign in_stall_o = !adv_fa;
  assign accept     = in_valid_i && adv_fa;

  // Mode decode
  always_comb begin
    absorb = 1'b0;
    fin    = 1'b0;
    case (mode_e'(in_req_i.mode))
      MODE_ABSORB:     absorb = 1'b1;
      MODE_ABSORB_FIN: begin
        absorb = 1'b1;
        fin    = 1'b1;
      end
      MODE_FIN:        fin = 1'b1;
      default: ;
    endcase
  end

  // Absorb round keyed by the block slices
  assign keys[0]  = {in_req_i.block_word1, in_req_i.block_word0};
  assign keys[1]  = {in_req_i.block_word3, in_req_i.block_word2};
  assign keys[2]  = {in_req_i.block_word5, in_req_i.block_word4};
  assign keys[3]  = {in_req_i.block_word7, in_req_i.block_word6};
  assign absorbed = absorb ? round_lanes(lane_q, keys) : lane_q;
  assign key0     = {NumLanes{XKey0}};
  assign key1     = {NumLanes{XKey1}};

  // Lane state next value
  always_comb begin
    lane_d = lane_q;
    if (accept) begin
      lane_d = fin ? LaneInit : absorbed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q  <= LaneInit;
      fa_v_q  <= 1'b0;
      fb_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      lane_q <= lane_d;
      if (adv_fa)  fa_v_q  <= accept && fin;
      if (adv_fb)  fb_v_q  <= fa_v_q;
      if (adv_out) out_v_q <= fb_v_q;
    end
  end

  // Finalization payload stages
  always_ff @(posedge clk_i) begin
    if (adv_fa)  fa_q  <= absorbed;
    if (adv_fb)  fb_q  <= round_lanes(fa_q, key0);
    if (adv_out) out_q <= round_lanes(fb_q, key1);
  end

  assign out_valid_o = out_v_q;
  assign out_rsp_o   = '{
    digest_word0: out_q[0][63:0],  digest_word1: out_q[0][127:64],
    digest_word2: out_q[1][63:0],  digest_word3: out_q[1][127:64],
    digest_word4: out_q[2][63:0],  digest_word5: out_q[2][127:64],
    digest_word6: out_q[3][63:0],  digest_word7: out_q[3][127:64]
  };

`ifndef SYNTHESIS
  // Input stalls only when every finalization stage is full and blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (fa_v_q && fb_v_q && out_v_q && out_stall_i))
    else $error("input stalled with room in the pipeline");

  // A plain absorb never enters the finalization pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_req_i.mode == MODE_ABSORB) |=> !fa_v_q)
    else $error("absorb request produced a digest");

  // A finalize reloads the lane constants
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && fin) |=> (lane_q == LaneInit))
    else $error("lanes not reloaded after finalize");
`endif

endmodule
`default_nettype wire
